// ----- sv/hcb_pkg.sv -----
// hcb_pkg: shared types, register codes and mod-26 helpers for the hill cipher block
// no dependencies; imported by hcb_mvmul, hill_cipher_block, hcb_port_props, hcb_checker and tb_top

package hcb_pkg;

	localparam int unsigned MAX_DIM     = 3;
	localparam int unsigned LETTER_W    = 5;
	localparam int unsigned KEY_W       = 45;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned PIPE_DEPTH  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_KEY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR = 2'd2;

	localparam logic [1:0] DIM_RESET   = 2'd2;
	localparam logic [1:0] DIM_THREE   = 2'd3;
	localparam logic       DIR_ENCRYPT = 1'b0;
	localparam logic       DIR_DECRYPT = 1'b1;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [8:0][LETTER_W-1:0] mat_t;
	typedef logic [2:0][LETTER_W-1:0] vec_t;
	typedef logic [11:0] wide_t;

	typedef struct packed {
		logic valid;
		logic key_invalid;
	} ctl_t;

	// reduce a 5-bit value into 0..25
	function automatic letter_t red26(input logic [LETTER_W-1:0] x);
		letter_t r;
		r = (x >= 5'd26) ? 5'(x - 5'd26) : x;
		return r;
	endfunction

	// additive inverse mod 26 of a reduced letter
	function automatic letter_t neg26(input letter_t x);
		letter_t r;
		r = (x == 5'd0) ? 5'd0 : 5'(5'd26 - x);
		return r;
	endfunction

	function automatic logic [9:0] mul5(input letter_t a, input letter_t b);
		logic [9:0] p;
		p = 10'(a) * 10'(b);
		return p;
	endfunction

	// x mod 26 for x below 4096: reciprocal estimate, then one correction
	function automatic letter_t mod26(input wide_t x);
		logic [20:0] p;
		logic [7:0]  q;
		wide_t       r;
		letter_t     m;
		p = 21'(x) * 21'd315;
		q = p[20:13];
		r = x - 12'(12'(q) * 12'd26);
		m = (r >= 12'd26) ? 5'(r - 12'd26) : 5'(r);
		return m;
	endfunction

	// multiplicative inverse mod 26, zero when there is none
	function automatic letter_t inv26(input letter_t d);
		letter_t r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/hcb_mvmul.sv -----
// hcb_mvmul: last pipeline stage, matrix times letter vector mod 26 into the output registers
// depends on hcb_pkg

module hcb_mvmul import hcb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl_in,
	input  mat_t    mat_in,
	input  vec_t    vec_in,
	output logic    done,
	output letter_t result_a,
	output letter_t result_b,
	output letter_t result_c,
	output logic    key_invalid
);

	vec_t row_r;
	logic valid_s6;
	vec_t res_s6;
	logic invalid_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_r[i] = mod26(12'(mul5(mat_in[3*i], vec_in[0]))
				+ 12'(mul5(mat_in[3*i+1], vec_in[1]))
				+ 12'(mul5(mat_in[3*i+2], vec_in[2])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s6     <= row_r;
		invalid_s6 <= ctl_in.key_invalid;
	end

	assign done        = valid_s6;
	assign result_a    = res_s6[0];
	assign result_b    = res_s6[1];
	assign result_c    = res_s6[2];
	assign key_invalid = invalid_s6;

endmodule

// ----- sv/hill_cipher_block.sv -----
// hill_cipher_block: hill cipher mod 26 with a 2x2 or 3x3 key, six-stage pipeline
// depends on hcb_pkg and hcb_mvmul
//
// channel   direction  handshake              payload
// request   in         start && !busy         letter_a, letter_b, letter_c
// result    out        done (one cycle)       result_a, result_b, result_c, key_invalid
// config    in         cfg_write              cfg_index, cfg_data
//
// one request per clock; each result reaches done through the six register stages: reduce,
// cofactors, determinant, inverse, scaled matrix, matrix-vector product;
// busy stays low
// reset clears the valid bits and sets key 0, dimension 2, encrypt
// results are a one-cycle strobe and cannot be held off

module hill_cipher_block import hcb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  letter_t              letter_a,
	input  letter_t              letter_b,
	input  letter_t              letter_c,
	output logic                 done,
	output letter_t              result_a,
	output letter_t              result_b,
	output letter_t              result_c,
	output logic                 key_invalid,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	logic [KEY_W-1:0] key_q;
	logic [1:0]       dim_q;
	logic             dir_q;
	logic             n3;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	mat_t k_s1, k_s2, k_s3, k_s4;
	vec_t v_s1, v_s2, v_s3, v_s4, v_s5;
	mat_t c_s2;
	mat_t adj2_s2;
	letter_t det2_s2;
	mat_t adj_s3, adj_s4;
	letter_t det_s3;
	letter_t inv_s4;
	logic invalid_s4, invalid_s5;
	mat_t m_s5;

	mat_t cof_r;
	letter_t inv_r;
	mat_t m_r;
	ctl_t ctl_s5;

	assign busy = 1'b0;
	assign n3   = (dim_q == DIM_THREE) && (MAX_DIM >= 3);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			dim_q <= DIM_RESET;
			dir_q <= DIR_ENCRYPT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY: key_q <= cfg_data;
				REG_DIM: dim_q <= cfg_data[1:0];
				REG_DIR: dir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: reduce key entries and letters
	always_ff @(posedge clk) begin
		for (int e = 0; e < 9; e++) begin
			k_s1[e] <= red26(key_q[LETTER_W*e +: LETTER_W]);
		end
		v_s1[0] <= red26(letter_a);
		v_s1[1] <= red26(letter_b);
		v_s1[2] <= n3 ? red26(letter_c) : 5'd0;
	end

	// stage 2: cofactors of the 3x3 key, 2x2 adjugate and determinant
	for (genvar i = 0; i < 3; i++) begin : g_cof_row
		for (genvar j = 0; j < 3; j++) begin : g_cof_col
			localparam int unsigned PA = ((i + 1) % 3) * 3 + (j + 1) % 3;
			localparam int unsigned PB = ((i + 2) % 3) * 3 + (j + 2) % 3;
			localparam int unsigned PC = ((i + 1) % 3) * 3 + (j + 2) % 3;
			localparam int unsigned PD = ((i + 2) % 3) * 3 + (j + 1) % 3;
			assign cof_r[3*i+j] = mod26(12'd650 + 12'(mul5(k_s1[PA], k_s1[PB]))
				- 12'(mul5(k_s1[PC], k_s1[PD])));
		end
	end

	always_ff @(posedge clk) begin
		k_s2    <= k_s1;
		v_s2    <= v_s1;
		c_s2    <= cof_r;
		det2_s2 <= mod26(12'd650 + 12'(mul5(k_s1[0], k_s1[4]))
			- 12'(mul5(k_s1[1], k_s1[3])));
		adj2_s2 <= {5'd0, 5'd0, 5'd0, 5'd0, k_s1[0], neg26(k_s1[3]), 5'd0,
			neg26(k_s1[1]), k_s1[4]};
	end

	// stage 3: 3x3 determinant, adjugate selection
	always_ff @(posedge clk) begin
		k_s3 <= k_s2;
		v_s3 <= v_s2;
		if (n3) begin
			det_s3 <= mod26(12'(mul5(k_s2[0], c_s2[0])) + 12'(mul5(k_s2[1], c_s2[1]))
				+ 12'(mul5(k_s2[2], c_s2[2])));
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					adj_s3[3*i+j] <= c_s2[3*j+i];
				end
			end
		end else begin
			det_s3 <= det2_s2;
			adj_s3 <= adj2_s2;
		end
	end

	// stage 4: inverse of the determinant
	assign inv_r = inv26(det_s3);

	always_ff @(posedge clk) begin
		k_s4       <= k_s3;
		v_s4       <= v_s3;
		adj_s4     <= adj_s3;
		inv_s4     <= inv_r;
		invalid_s4 <= (dir_q == DIR_DECRYPT) && (inv_r == 5'd0);
	end

	// stage 5: effective matrix, key for encrypt, scaled adjugate for decrypt, zeros for a singular decrypt key
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (dir_q == DIR_ENCRYPT) begin
					m_r[3*i+j] = (!n3 && (i == 2 || j == 2)) ? 5'd0 : k_s4[3*i+j];
				end else if (invalid_s4) begin
					m_r[3*i+j] = 5'd0;
				end else begin
					m_r[3*i+j] = mod26(12'(mul5(adj_s4[3*i+j], inv_s4)));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s5       <= m_r;
		v_s5       <= v_s4;
		invalid_s5 <= invalid_s4;
	end

	assign ctl_s5.valid       = valid_s5;
	assign ctl_s5.key_invalid = invalid_s5;

	// stage 6: product and output registers
	hcb_mvmul u_mvmul (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_in      (ctl_s5),
		.mat_in      (m_s5),
		.vec_in      (v_s5),
		.done        (done),
		.result_a    (result_a),
		.result_b    (result_b),
		.result_c    (result_c),
		.key_invalid (key_invalid)
	);

endmodule

// ----- sv/hcb_checker.sv -----
// hcb_port_props: port-level assertions for hill_cipher_block, bound to the top level
// depends on hcb_pkg

module hcb_port_props import hcb_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input letter_t result_a,
	input letter_t result_b,
	input letter_t result_c,
	input logic    key_invalid
);

	// every request gives a result
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("request without result");

	// no result without a request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without request");

	// letters stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result_a <= 5'd25 && result_b <= 5'd25 && result_c <= 5'd25))
		else $error("result letter out of range");

	// a singular key while decrypting gives zero letters
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && key_invalid) |-> (result_a == 5'd0 && result_b == 5'd0 && result_c == 5'd0))
		else $error("invalid key with nonzero letters");

endmodule

bind hill_cipher_block hcb_port_props u_port_props (.*);

// ----- dv/hcb_checker.sv -----
// hcb_checker: watches request, result and config traffic of hill_cipher_block,
// predicts each result block and compares it field by field; depends on hcb_pkg
`timescale 1ns / 1ps

module hcb_checker import hcb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  letter_t              letter_a,
	input  letter_t              letter_b,
	input  letter_t              letter_c,
	input  logic                 done,
	input  letter_t              result_a,
	input  letter_t              result_b,
	input  letter_t              result_c,
	input  logic                 key_invalid,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		letter_t a;
		letter_t b;
		letter_t c;
		logic    invalid;
	} cipher_block_t;

	cipher_block_t       expected_blocks[$];
	cipher_block_t       want;
	logic [KEY_W-1:0]    key_q;
	logic [1:0]          dim_q;
	logic                dir_q;

	function automatic cipher_block_t predict_block(input logic [KEY_W-1:0] key,
			input logic [1:0] dim, input logic dir, input letter_t a, input letter_t b,
			input letter_t c);
		int            k[3][3];
		int            adj[3][3];
		int            cof[3][3];
		int            v[3];
		int            res[3];
		int            n;
		int            det;
		int            scale;
		int            s;
		cipher_block_t r;
		n = (dim == DIM_THREE) ? 3 : 2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				k[i][j] = key[5*(i*3+j) +: 5] % 26;
				adj[i][j] = 0;
			end
		end
		v[0] = a % 26;
		v[1] = b % 26;
		v[2] = (n == 3) ? c % 26 : 0;
		det = 1;
		if (dir == DIR_DECRYPT) begin
			if (n == 2) begin
				det = k[0][0] * k[1][1] - k[0][1] * k[1][0];
				adj[0][0] = k[1][1];
				adj[0][1] = -k[0][1];
				adj[1][0] = -k[1][0];
				adj[1][1] = k[0][0];
			end else begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						cof[i][j] = k[(i+1)%3][(j+1)%3] * k[(i+2)%3][(j+2)%3]
							- k[(i+1)%3][(j+2)%3] * k[(i+2)%3][(j+1)%3];
					end
				end
				det = k[0][0] * cof[0][0] + k[0][1] * cof[0][1] + k[0][2] * cof[0][2];
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						adj[i][j] = cof[j][i];
					end
				end
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					adj[i][j] = k[i][j];
				end
			end
		end
		det = ((det % 26) + 26) % 26;
		scale = 0;
		for (int x = 1; x < 26; x++) begin
			if ((det * x) % 26 == 1) begin
				scale = x;
			end
		end
		for (int i = 0; i < 3; i++) begin
			s = 0;
			if (i < n) begin
				for (int j = 0; j < n; j++) begin
					s += adj[i][j] * v[j];
				end
			end
			res[i] = (((s * scale) % 26) + 26) % 26;
		end
		r.a = 5'(res[0]);
		r.b = 5'(res[1]);
		r.c = 5'(res[2]);
		r.invalid = (scale == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q = '0;
			dim_q = DIM_RESET;
			dir_q = DIR_ENCRYPT;
			expected_blocks.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (expected_blocks.size() == 0) begin
					$display("%0t: result %0d %0d %0d invalid %0b with no request pending",
						$time, result_a, result_b, result_c, key_invalid);
					fail_count++;
				end else begin
					want = expected_blocks.pop_front();
					check_field("result_a", want.a, result_a);
					check_field("result_b", want.b, result_b);
					check_field("result_c", want.c, result_c);
					check_field("key_invalid", want.invalid, key_invalid);
				end
			end
			if (start && !busy) begin
				expected_blocks.push_back(predict_block(key_q, dim_q, dir_q,
					letter_a, letter_b, letter_c));
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_KEY: key_q = cfg_data;
					REG_DIM: dim_q = cfg_data[1:0];
					REG_DIR: dir_q = cfg_data[0];
					default: ;
				endcase
			end
			pending = expected_blocks.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: drives letter blocks and key/mode settings into hill_cipher_block
// under random idling; depends on hcb_pkg, hill_cipher_block and hcb_checker
`timescale 1ns / 1ps

module tb_top import hcb_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int LIMIT         = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int QUIET_PHASES  = 2;
	localparam int PHASE_BLOCKS  = 80;

	// row-major entries, last entry first in each concatenation
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [KEY_W-1:0] KEY_WIDE = {5'd29, 5'd28, 5'd5, 5'd27, 5'd30, 5'd0,
		5'd1, 5'd26, 5'd31};
	localparam logic [KEY_W-1:0] KEY_PAIR = {5'd0, 5'd0, 5'd0, 5'd0, 5'd5, 5'd2,
		5'd0, 5'd3, 5'd3};
	localparam logic [KEY_W-1:0] KEY_TRIO = {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13,
		5'd1, 5'd24, 5'd6};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	letter_t              letter_a;
	letter_t              letter_b;
	letter_t              letter_c;
	logic                 done;
	letter_t              result_a;
	letter_t              result_b;
	letter_t              result_c;
	logic                 key_invalid;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;
	int                   cycles = 0;
	logic                 idle_on;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	hill_cipher_block dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.letter_a    (letter_a),
		.letter_b    (letter_b),
		.letter_c    (letter_c),
		.done        (done),
		.result_a    (result_a),
		.result_b    (result_b),
		.result_c    (result_c),
		.key_invalid (key_invalid),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	hcb_checker cipher_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.letter_a    (letter_a),
		.letter_b    (letter_b),
		.letter_c    (letter_c),
		.done        (done),
		.result_a    (result_a),
		.result_b    (result_b),
		.result_c    (result_c),
		.key_invalid (key_invalid),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic letter_t rand_letter();
		letter_t l;
		l = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25));
		return l;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'({$urandom, $urandom});
		return k;
	endfunction

	task automatic send_block(input letter_t a, input letter_t b, input letter_t c);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		letter_a <= a;
		letter_b <= b;
		letter_c <= c;
		do @(posedge clk); while (busy);
	endtask

	// drain all requests in flight
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] dim_word,
			input logic [KEY_W-1:0] dir_word);
		settle();
		write_reg(REG_KEY, key);
		write_reg(REG_DIM, dim_word);
		write_reg(REG_DIR, dir_word);
	endtask

	initial begin
		logic [KEY_W-1:0] dim_word;
		logic [KEY_W-1:0] dir_word;
		logic [1:0]       dim;
		arst_n = 1'b0;
		start = 1'b0;
		letter_a = '0;
		letter_b = '0;
		letter_c = '0;
		cfg_write = 1'b0;
		cfg_index = REG_KEY;
		cfg_data = '0;
		idle_on = 1'b1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// settings straight out of reset
		send_block(5'd0, 5'd0, 5'd0);
		send_block(5'd31, 5'd31, 5'd31);

		// 3x3 encrypt, key entries above 25
		set_config(KEY_WIDE, KEY_W'(DIM_THREE), KEY_W'(DIR_ENCRYPT));
		send_block(5'd25, 5'd25, 5'd25);
		send_block(5'd26, 5'd27, 5'd31);
		send_block(5'd1, 5'd2, 5'd3);
		send_block(5'd0, 5'd0, 5'd0);

		set_config(KEY_PAIR, KEY_W'(DIM_RESET), KEY_W'(DIR_DECRYPT));
		send_block(5'd25, 5'd0, 5'd17);
		send_block(5'd7, 5'd19, 5'd31);
		send_block(5'd30, 5'd4, 5'd9);

		set_config(KEY_TRIO, KEY_W'(DIM_THREE), KEY_W'(DIR_DECRYPT));
		send_block(5'd2, 5'd0, 5'd19);
		send_block(5'd14, 5'd4, 5'd25);
		send_block(5'd31, 5'd29, 5'd0);

		// singular key while decrypting
		set_config(KEY_ONES, KEY_W'(DIM_THREE), KEY_W'(DIR_DECRYPT));
		send_block(5'd5, 5'd6, 5'd7);
		send_block(5'd25, 5'd25, 5'd25);

		set_config(KEY_ONES, KEY_W'(DIM_RESET), KEY_W'(DIR_ENCRYPT));
		send_block(5'd3, 5'd26, 5'd4);

		// dimension codes below 2 fall back to 2x2
		set_config(KEY_PAIR, KEY_W'(2'd0), KEY_W'(DIR_DECRYPT));
		send_block(5'd11, 5'd12, 5'd13);
		settle();
		write_reg(REG_DIM, KEY_W'(2'd1));
		send_block(5'd20, 5'd21, 5'd22);

		// write to an unused index is dropped
		settle();
		write_reg(REG_SPARE, KEY_ONES);
		send_block(5'd8, 5'd9, 5'd10);

		set_config(KEY_ONES, KEY_W'(DIM_RESET), KEY_W'(DIR_DECRYPT));
		send_block(5'd1, 5'd1, 5'd1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			dim = ($urandom_range(0, 1) == 1) ? DIM_THREE : 2'($urandom_range(0, 2));
			dim_word = rand_key();
			dim_word[1:0] = dim;
			dir_word = rand_key();
			if (p == 0) begin
				dim_word[1:0] = DIM_THREE;
				dir_word[0] = DIR_ENCRYPT;
				set_config(KEY_ONES, dim_word, dir_word);
			end else begin
				set_config(rand_key(), dim_word, dir_word);
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_SPARE, rand_key());
			end
			idle_on = (p < RANDOM_PHASES - QUIET_PHASES);
			repeat (PHASE_BLOCKS) send_block(rand_letter(), rand_letter(), rand_letter());
		end

		settle();
		repeat (PIPE_DEPTH + 4) @(negedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
